// ===== src/tpch_pkg.sv =====
// Shared types, constants and register codes for the touch panel hit test.
package tpch_pkg;

    localparam int RawW  = 16;
    localparam int PosW  = 8;
    localparam int CntW  = $clog2(RawW);
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_X_PRESS_MIN = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_Y_PRESS_MIN = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_X_OFFSET    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_Y_OFFSET    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_X_DIVISOR   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_Y_DIVISOR   = 3'd5;

    // register reset values
    localparam logic [7:0]      RST_X_PRESS_MIN = 8'd10;
    localparam logic [7:0]      RST_Y_PRESS_MIN = 8'd20;
    localparam logic [RawW-1:0] RST_X_OFFSET    = 16'd3150;
    localparam logic [RawW-1:0] RST_Y_OFFSET    = 16'd6500;
    localparam logic [RawW-1:0] RST_X_DIVISOR   = 16'd246;
    localparam logic [RawW-1:0] RST_Y_DIVISOR   = 16'd409;

    localparam logic [3:0]      NEG_NIBBLE_MASK = 4'hF;
    localparam logic [PosW-1:0] Y_TOP           = 8'd127;

    // hit regions
    localparam logic [PosW-1:0] RED_X_LO   = 8'd203;
    localparam logic [PosW-1:0] GREEN_X_LO = 8'd215;
    localparam logic [PosW-1:0] BLUE_X_LO  = 8'd227;
    localparam logic [PosW-1:0] LAMP_X_SPAN = 8'd6;
    localparam logic [PosW-1:0] LAMP_ON_Y_LO  = 8'd113;
    localparam logic [PosW-1:0] LAMP_OFF_Y_LO = 8'd121;
    localparam logic [PosW-1:0] LAMP_OFF_Y_HI = 8'd127;
    localparam logic [PosW-1:0] ALARM_X_LO = 8'd190;
    localparam logic [PosW-1:0] ALARM_X_HI = 8'd210;
    localparam logic [PosW-1:0] ALARM_Y_LO = 8'd10;
    localparam logic [PosW-1:0] ALARM_Y_HI = 8'd30;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIVX = 4'b0010,
        S_DIVY = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;    // capture an input item and start the X division
        logic step;    // one restoring division step
        logic sel_y;   // divide by the Y divisor
        logic x_done;  // last X step: keep X quotient, start Y
        logic y_done;  // last Y step: keep Y coordinate
        logic commit;  // update held state and present the result
    } t_cmd;

endpackage

// ===== src/tpch_ctrl.sv =====
// Controller state machine: sequences capture, two divisions and result hand-off.
module tpch_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  logic                  i_pressed,
    output tpch_pkg::t_cmd        o_cmd
);
    import tpch_pkg::*;

    t_state            r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              slot_free;
    logic              last_step;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign last_step  = (r_cnt == CntW'(RawW - 1));
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIVX;
                end
            end
            S_DIVX: begin
                // skip both divisions when the sample is no touch
                if (!i_pressed) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.step   = 1'b1;
                    o_cmd.x_done = last_step;
                    n_cnt        = r_cnt + 1'b1;
                    if (last_step) begin
                        n_state = S_DIVY;
                    end
                end
            end
            S_DIVY: begin
                o_cmd.step   = 1'b1;
                o_cmd.sel_y  = 1'b1;
                o_cmd.y_done = last_step;
                n_cnt        = r_cnt + 1'b1;
                if (last_step) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_out_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && slot_free) |=> (r_state == S_IDLE))
        else $error("result stage did not return to idle");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DIVX && r_cnt == '0))
        else $error("accepted item did not start the X division");

    a_x_to_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX && i_pressed && last_step) |=> (r_state == S_DIVY && r_cnt == '0))
        else $error("X division did not hand over to Y");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the result state");
`endif

endmodule

// ===== src/tpch_dp.sv =====
// Datapath: configuration registers, sample cleanup, shared divider, hit regions.
module tpch_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpch_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tpch_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic [tpch_pkg::RawW-1:0]      i_raw_x,
    input  logic [tpch_pkg::RawW-1:0]      i_raw_y,
    input  tpch_pkg::t_cmd                 i_cmd,
    output logic                           o_pressed,
    output logic                           o_out_pressed,
    output logic [tpch_pkg::PosW-1:0]      o_x_pos,
    output logic [tpch_pkg::PosW-1:0]      o_y_pos,
    output logic                           o_red_on,
    output logic                           o_green_on,
    output logic                           o_blue_on,
    output logic                           o_alarm_on
);
    import tpch_pkg::*;

    logic [7:0]      r_x_min, r_y_min;
    logic [RawW-1:0] r_x_off, r_y_off, r_x_div, r_y_div;

    logic [RawW-1:0] cx, cy;
    logic            in_pressed;

    logic            r_pressed;
    logic [RawW-1:0] r_quo, n_quo;
    logic [RawW-1:0] r_rem, n_rem;
    logic [RawW-1:0] r_dy;
    logic [PosW-1:0] r_qx, r_qy;

    logic [RawW:0]   rem_sh;
    logic [RawW:0]   dvs;
    logic            ge;
    logic [RawW:0]   rem_sub;
    logic [RawW-1:0] quo_step;

    logic            r_out_pressed;
    logic [PosW-1:0] r_held_x, r_held_y;
    logic            r_red, r_green, r_blue, r_alarm;
    logic            n_red, n_green, n_blue, n_alarm;

    function automatic logic lamp_next(input logic cur, input logic [PosW-1:0] x,
                                       input logic [PosW-1:0] y, input logic [PosW-1:0] xlo);
        logic hit_x;
        logic res;
        hit_x = (x >= xlo) && ({1'b0, x} < ({1'b0, xlo} + {1'b0, LAMP_X_SPAN}));
        res = cur;
        if (hit_x && y >= LAMP_ON_Y_LO && y < LAMP_OFF_Y_LO) res = 1'b1;
        if (hit_x && y >= LAMP_OFF_Y_LO && y < LAMP_OFF_Y_HI) res = 1'b0;
        return res;
    endfunction

    // zero a word whose low nibble marks a negative reading
    assign cx = ((i_raw_x[3:0] & NEG_NIBBLE_MASK) != '0) ? '0 : i_raw_x;
    assign cy = ((i_raw_y[3:0] & NEG_NIBBLE_MASK) != '0) ? '0 : i_raw_y;
    assign in_pressed = (cx[RawW-1:RawW-8] >= r_x_min) && (cy[RawW-1:RawW-8] >= r_y_min);

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[RawW-1]};
    assign dvs      = {1'b0, (i_cmd.sel_y ? r_y_div : r_x_div)};
    assign ge       = (rem_sh >= dvs);
    assign rem_sub  = ge ? (rem_sh - dvs) : rem_sh;
    assign quo_step = {r_quo[RawW-2:0], ge};

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_cmd.load) begin
            n_quo = cx - r_x_off;
            n_rem = '0;
        end else if (i_cmd.x_done) begin
            n_quo = r_dy;
            n_rem = '0;
        end else if (i_cmd.step) begin
            n_quo = quo_step;
            n_rem = rem_sub[RawW-1:0];
        end
    end

    assign n_red   = lamp_next(r_red,   r_qx, r_qy, RED_X_LO);
    assign n_green = lamp_next(r_green, r_qx, r_qy, GREEN_X_LO);
    assign n_blue  = lamp_next(r_blue,  r_qx, r_qy, BLUE_X_LO);
    assign n_alarm = r_alarm ^ ((r_qx >= ALARM_X_LO) && (r_qx < ALARM_X_HI) &&
                                (r_qy >= ALARM_Y_LO) && (r_qy < ALARM_Y_HI));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= RST_X_PRESS_MIN;
            r_y_min <= RST_Y_PRESS_MIN;
            r_x_off <= RST_X_OFFSET;
            r_y_off <= RST_Y_OFFSET;
            r_x_div <= RST_X_DIVISOR;
            r_y_div <= RST_Y_DIVISOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_PRESS_MIN: r_x_min <= i_cfg_data[7:0];
                REG_Y_PRESS_MIN: r_y_min <= i_cfg_data[7:0];
                REG_X_OFFSET:    r_x_off <= i_cfg_data;
                REG_Y_OFFSET:    r_y_off <= i_cfg_data;
                REG_X_DIVISOR:   r_x_div <= i_cfg_data;
                REG_Y_DIVISOR:   r_y_div <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // work registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_cmd.load) begin
            r_pressed <= in_pressed;
            r_dy      <= cy - r_y_off;
        end
        if (i_cmd.x_done) begin
            r_qx <= quo_step[PosW-1:0];
        end
        if (i_cmd.y_done) begin
            r_qy <= Y_TOP - quo_step[PosW-1:0];
        end
    end

    // held state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pressed <= 1'b0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_red         <= 1'b0;
            r_green       <= 1'b0;
            r_blue        <= 1'b0;
            r_alarm       <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_pressed <= r_pressed;
            if (r_pressed) begin
                r_held_x <= r_qx;
                r_held_y <= r_qy;
                r_red    <= n_red;
                r_green  <= n_green;
                r_blue   <= n_blue;
                r_alarm  <= n_alarm;
            end
        end
    end

    assign o_pressed     = r_pressed;
    assign o_out_pressed = r_out_pressed;
    assign o_x_pos       = r_held_x;
    assign o_y_pos       = r_held_y;
    assign o_red_on      = r_red;
    assign o_green_on    = r_green;
    assign o_blue_on     = r_blue;
    assign o_alarm_on    = r_alarm;

endmodule

// ===== src/touch_panel_coordinate_hit_test.sv =====
// A sample with no touch skips the divisions; a touch runs two 16-step restoring
// divisions on one shared divider. A new item is taken only after the previous
// result is committed, but it is taken while that result waits on the output.
// Reset (i_rst_n low, synchronous) loads register defaults, clears held state.
// Configuration writes are taken every cycle.
module touch_panel_coordinate_hit_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // raw_x[15:0], raw_y[31:16]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // x_pos[7:0], y_pos[15:8], red_on[16], green_on[17], blue_on[18], alarm_on[19], zero
    output logic [23:0]                   m_axis_tdata,
    output logic                          m_axis_tuser,   // pressed
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tpch_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [tpch_pkg::CfgDataW-1:0] i_cfg_data
);
    import tpch_pkg::*;

    t_cmd            cmd;
    logic            pressed;
    logic [PosW-1:0] x_pos, y_pos;
    logic            red_on, green_on, blue_on, alarm_on;

    assign o_cfg_ready = 1'b1;

    tpch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_pressed   (pressed),
        .o_cmd       (cmd)
    );

    tpch_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_raw_x       (s_axis_tdata[15:0]),
        .i_raw_y       (s_axis_tdata[31:16]),
        .i_cmd         (cmd),
        .o_pressed     (pressed),
        .o_out_pressed (m_axis_tuser),
        .o_x_pos       (x_pos),
        .o_y_pos       (y_pos),
        .o_red_on      (red_on),
        .o_green_on    (green_on),
        .o_blue_on     (blue_on),
        .o_alarm_on    (alarm_on)
    );

    assign m_axis_tdata = {4'b0000, alarm_on, blue_on, green_on, red_on, y_pos, x_pos};

endmodule
